FILE: rtl/bfa_pkg.sv
package bfa_pkg;

	localparam int unsigned NUM_BLOCKS_DEF  = 32768;
	localparam int unsigned BLOCK_BYTES_DEF = 4096;
	localparam int unsigned MEMORY_KIB_W    = 18;
	localparam logic [MEMORY_KIB_W-1:0] MEMORY_KIB_RST = 18'd131072;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned QDEPTH  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_RESET_MAP   = 3'd0,
		CMD_FREE_REGION = 3'd1,
		CMD_RESERVE     = 3'd2,
		CMD_ALLOC       = 3'd3,
		CMD_FREE        = 3'd4,
		CMD_BAD5        = 3'd5,
		CMD_BAD6        = 3'd6,
		CMD_BAD7        = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		OP_INIT,
		OP_MARK,
		OP_ALLOC,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        val;
		logic        set0;
		logic [31:0] first;
		logic [32:0] count;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_SCAN,
		ST_SET0,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/bfa_if.sv
interface bfa_req_if;
	logic                         valid;
	logic                         ready;
	logic [bfa_pkg::CMD_W-1:0]    cmd;
	logic [bfa_pkg::ADDR_W-1:0]   address;
	logic [bfa_pkg::LEN_W-1:0]    length;
	modport source(output valid, cmd, address, length, input ready);
	modport sink(input valid, cmd, address, length, output ready);
endinterface

interface bfa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [bfa_pkg::ADDR_W-1:0]   alloc_address;
	logic [bfa_pkg::CNT_W-1:0]    used_blocks;
	logic [bfa_pkg::CNT_W-1:0]    free_blocks;
	modport source(output valid, ok, alloc_address, used_blocks, free_blocks, input ready);
	modport sink(input valid, ok, alloc_address, used_blocks, free_blocks, output ready);
endinterface

FILE: rtl/bitmap_frame_allocator.sv
// First-fit bitmap block allocator. Requests are classified into a two-entry
// queue and carried out by a sequencer over a one-word-per-cycle bitmap memory
// of (NUM_BLOCKS+31)/32 words. A region mark or free reads and then writes
// each touched word, an alloc scans block by block and then marks the run,
// and reset_map and a memory_kib write rewrite every word (also after reset,
// during which no request is started).
module bitmap_frame_allocator #(
	parameter int unsigned NUM_BLOCKS  = bfa_pkg::NUM_BLOCKS_DEF,
	parameter int unsigned BLOCK_BYTES = bfa_pkg::BLOCK_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bfa_pkg::MEMORY_KIB_W-1:0] cfg_wdata,
	bfa_req_if.sink                          req,
	bfa_rsp_if.source                        rsp
);
	logic job_valid, job_ready;
	bfa_pkg::job_t job;

	bfa_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
		.clk, .arst_n, .req, .job_valid, .job_ready, .job
	);

	bfa_back #(.NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .job_valid, .job_ready, .job, .rsp
	);
endmodule

FILE: rtl/bfa_front.sv
module bfa_front #(
	parameter int unsigned BLOCK_BYTES = bfa_pkg::BLOCK_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	bfa_req_if.sink        req,
	output logic           job_valid,
	input  logic           job_ready,
	output bfa_pkg::job_t  job
);
	localparam int unsigned SH = $clog2(BLOCK_BYTES);

	bfa_pkg::job_t q_q [bfa_pkg::QDEPTH];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	bfa_pkg::job_t nj;

	always_comb begin
		nj = '0;
		nj.first = req.address >> SH;
		nj.count = {1'b0, req.length >> SH};
		unique case (bfa_pkg::cmd_t'(req.cmd))
			bfa_pkg::CMD_RESET_MAP: nj.op = bfa_pkg::OP_INIT;
			bfa_pkg::CMD_FREE_REGION: begin
				nj.op = bfa_pkg::OP_MARK;
				nj.set0 = 1'b1;
			end
			bfa_pkg::CMD_RESERVE: begin
				nj.op = bfa_pkg::OP_MARK;
				nj.val = 1'b1;
			end
			bfa_pkg::CMD_ALLOC: begin
				nj.op = bfa_pkg::OP_ALLOC;
				nj.val = 1'b1;
				nj.count = {1'b0, req.length};
			end
			bfa_pkg::CMD_FREE: begin
				nj.op = bfa_pkg::OP_MARK;
				nj.count = {1'b0, req.length};
			end
			default: nj.op = bfa_pkg::OP_NONE;
		endcase
	end

	assign req.ready = (cnt_q != 2'(bfa_pkg::QDEPTH));
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) q_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (req.valid && req.ready) wp_q <= wp_q + 1'b1;
			if (job_valid && job_ready) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(req.valid && req.ready) - 2'(job_valid && job_ready);
		end
	end
endmodule

FILE: rtl/bfa_back.sv
module bfa_back #(
	parameter int unsigned NUM_BLOCKS  = bfa_pkg::NUM_BLOCKS_DEF,
	parameter int unsigned BLOCK_BYTES = bfa_pkg::BLOCK_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bfa_pkg::MEMORY_KIB_W-1:0] cfg_wdata,
	input  logic                             job_valid,
	output logic                             job_ready,
	input  bfa_pkg::job_t                    job,
	bfa_rsp_if.source                        rsp
);
	localparam int unsigned WORDS = (NUM_BLOCKS + 31) / 32;
	localparam int unsigned WA = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned BW = $clog2(NUM_BLOCKS) + 1;
	localparam int unsigned SH = $clog2(BLOCK_BYTES);
	localparam int unsigned KSH = (SH > 10) ? SH - 10 : 0;
	localparam int unsigned KUP = (SH < 10) ? 10 - SH : 0;
	localparam bfa_pkg::job_t JOB_IDLE = '{
		op: bfa_pkg::OP_NONE, val: 1'b0, set0: 1'b0, first: '0, count: '0
	};

	logic [31:0] mem [WORDS];
	logic [31:0] rd_q;
	logic [WA-1:0] raddr, waddr;
	logic re, we;
	logic [31:0] wd;

	logic [bfa_pkg::MEMORY_KIB_W-1:0] kib_q;
	logic [BW-1:0] m_q, m_n;
	logic [BW-1:0] used_q, used_n;
	bfa_pkg::state_t st_q, st_n;
	bfa_pkg::job_t j_q, j_n;
	logic [32:0] b_q, b_n;
	logic [32:0] run_q, run_n;
	logic [32:0] lim_q, lim_n;
	logic [32:0] start_q, start_n;
	logic ok_q, ok_n;
	logic [31:0] aa_q, aa_n;
	logic rv_q, rv_n;
	logic ro_q, ro_n;
	logic [31:0] ra_q, ra_n;
	logic [bfa_pkg::CNT_W-1:0] ru_q, ru_n, rf_q, rf_n;
	logic init_pend_q, init_pend_n;
	logic [WA:0] iw_q, iw_n;

	logic [63:0] mwide;
	logic [5:0] lo, hi;
	logic [31:0] mk, nw, chg;
	logic [BW-1:0] dcnt;
	logic [33:0] endb;
	logic bit_now;

	function automatic logic [bfa_pkg::CNT_W-1:0] CNT_TRUNC(input logic [BW-1:0] v);
		logic [BW+bfa_pkg::CNT_W-1:0] t;
		t = {{bfa_pkg::CNT_W{1'b0}}, v};
		return t[bfa_pkg::CNT_W-1:0];
	endfunction

	always_comb begin
		mwide = 64'(kib_q);
		if (KUP > 0) mwide = mwide << KUP;
		else mwide = mwide >> KSH;
		if (mwide > 64'(NUM_BLOCKS)) m_n = BW'(NUM_BLOCKS);
		else m_n = BW'(mwide);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wd;
		if (re) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kib_q <= bfa_pkg::MEMORY_KIB_RST;
			st_q <= bfa_pkg::ST_INIT;
			j_q <= JOB_IDLE;
			init_pend_q <= 1'b0;
			used_q <= '0;
			m_q <= '0;
			rv_q <= 1'b0;
			iw_q <= '0;
		end else begin
			if (cfg_we) kib_q <= cfg_wdata;
			st_q <= st_n;
			j_q <= j_n;
			init_pend_q <= init_pend_n | cfg_we;
			used_q <= used_n;
			m_q <= m_n;
			rv_q <= rv_n;
			iw_q <= iw_n;
		end
	end

	always_ff @(posedge clk) begin
		b_q <= b_n;
		run_q <= run_n;
		lim_q <= lim_n;
		start_q <= start_n;
		ok_q <= ok_n;
		aa_q <= aa_n;
		ro_q <= ro_n;
		ra_q <= ra_n;
		ru_q <= ru_n;
		rf_q <= rf_n;
	end

	assign rsp.valid = rv_q;
	assign rsp.ok = ro_q;
	assign rsp.alloc_address = ra_q;
	assign rsp.used_blocks = ru_q;
	assign rsp.free_blocks = rf_q;

	always_comb begin
		st_n = st_q;
		j_n = j_q;
		b_n = b_q;
		run_n = run_q;
		lim_n = lim_q;
		start_n = start_q;
		ok_n = ok_q;
		aa_n = aa_q;
		used_n = used_q;
		rv_n = rv_q;
		ro_n = ro_q;
		ra_n = ra_q;
		ru_n = ru_q;
		rf_n = rf_q;
		init_pend_n = init_pend_q;
		iw_n = iw_q;
		job_ready = 1'b0;
		re = 1'b0;
		we = 1'b0;
		raddr = b_q[WA+4:5];
		waddr = b_q[WA+4:5];
		wd = '0;
		lo = '0;
		hi = '0;
		mk = '0;
		nw = '0;
		chg = '0;
		dcnt = '0;
		endb = '0;
		bit_now = rd_q[b_q[4:0]];
		if (rsp.valid && rsp.ready) rv_n = 1'b0;
		unique case (st_q)
			bfa_pkg::ST_IDLE: begin
				if (init_pend_q) begin
					init_pend_n = 1'b0;
					iw_n = '0;
					j_n.op = bfa_pkg::OP_NONE;
					st_n = bfa_pkg::ST_INIT;
				end else if (job_valid && !rv_n) begin
					job_ready = 1'b1;
					j_n = job;
					ok_n = 1'b1;
					aa_n = '0;
					b_n = {1'b0, job.first};
					endb = 34'(job.first) + 34'(job.count);
					lim_n = (endb > 34'(m_q)) ? 33'(m_q) : endb[32:0];
					unique case (job.op)
						bfa_pkg::OP_INIT: begin
							iw_n = '0;
							st_n = bfa_pkg::ST_INIT;
						end
						bfa_pkg::OP_MARK: st_n = bfa_pkg::ST_MARK_RD;
						bfa_pkg::OP_ALLOC: begin
							b_n = '0;
							run_n = '0;
							if (job.count == '0 ||
							    33'(m_q - used_q) < job.count) begin
								ok_n = 1'b0;
								st_n = bfa_pkg::ST_DONE;
							end else begin
								raddr = '0;
								re = 1'b1;
								st_n = bfa_pkg::ST_SCAN;
							end
						end
						default: begin
							ok_n = 1'b0;
							st_n = bfa_pkg::ST_DONE;
						end
					endcase
				end
			end
			bfa_pkg::ST_INIT: begin
				waddr = iw_q[WA-1:0];
				wd = '1;
				we = 1'b1;
				iw_n = iw_q + 1'b1;
				if (iw_q == (WA+1)'(WORDS - 1)) begin
					used_n = m_q;
					iw_n = '0;
					st_n = (j_q.op == bfa_pkg::OP_INIT) ? bfa_pkg::ST_DONE
						: bfa_pkg::ST_IDLE;
				end
			end
			bfa_pkg::ST_MARK_RD: begin
				if (b_q >= lim_q) begin
					st_n = j_q.set0 ? bfa_pkg::ST_SET0 : bfa_pkg::ST_DONE;
					if (j_q.set0) begin
						b_n = '0;
						re = 1'b1;
						raddr = '0;
					end
				end else begin
					re = 1'b1;
					st_n = bfa_pkg::ST_MARK_WR;
				end
			end
			bfa_pkg::ST_MARK_WR: begin
				lo = {1'b0, b_q[4:0]};
				if ({b_q[32:5], 5'd0} + 33'd32 <= lim_q) hi = 6'd32;
				else hi = 6'(lim_q - {b_q[32:5], 5'd0});
				mk = (hi == 6'd32 ? 32'hffffffff : ((32'd1 << hi) - 32'd1))
					& ~((32'd1 << lo) - 32'd1);
				if (j_q.val) begin
					chg = mk & ~rd_q;
					nw = rd_q | mk;
					dcnt = BW'($countones(chg));
					used_n = used_q + dcnt;
				end else begin
					chg = mk & rd_q;
					nw = rd_q & ~mk;
					dcnt = BW'($countones(chg));
					used_n = used_q - dcnt;
				end
				wd = nw;
				we = 1'b1;
				b_n = {b_q[32:5], 5'd0} + 33'd32;
				st_n = bfa_pkg::ST_MARK_RD;
			end
			bfa_pkg::ST_SET0: begin
				if (m_q != '0) begin
					waddr = '0;
					wd = rd_q | 32'd1;
					we = 1'b1;
					if (!rd_q[0]) used_n = used_q + 1'b1;
				end
				st_n = bfa_pkg::ST_DONE;
			end
			bfa_pkg::ST_SCAN: begin
				if (b_q >= 33'(m_q)) begin
					ok_n = 1'b0;
					st_n = bfa_pkg::ST_DONE;
				end else begin
					if (bit_now) run_n = '0;
					else run_n = run_q + 1'b1;
					b_n = b_q + 1'b1;
					if (!bit_now && run_n == j_q.count) begin
						start_n = b_q + 33'd1 - j_q.count;
						b_n = b_q + 33'd1 - j_q.count;
						aa_n = 32'(b_q + 33'd1 - j_q.count) << SH;
						lim_n = b_q + 33'd1;
						j_n.val = 1'b1;
						st_n = bfa_pkg::ST_MARK_RD;
					end else if (b_q[4:0] == 5'd31) begin
						raddr = b_n[WA+4:5];
						re = 1'b1;
					end
				end
			end
			bfa_pkg::ST_DONE: begin
				if (!rv_n) begin
					rv_n = 1'b1;
					ro_n = ok_q;
					ra_n = aa_q;
					ru_n = CNT_TRUNC(used_q);
					rf_n = CNT_TRUNC(m_q - used_q);
					st_n = bfa_pkg::ST_IDLE;
				end
			end
			default: st_n = bfa_pkg::ST_IDLE;
		endcase
	end
endmodule

FILE: rtl/bfa_checker.sv
module bfa_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_ok,
	input logic [31:0] rsp_alloc_address,
	input logic [15:0] rsp_used_blocks,
	input logic [15:0] rsp_free_blocks
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alloc_address))
		else $error("response dropped");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_alloc_address == 32'd0)
		else $error("failed request carries address");
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (17'(rsp_used_blocks) + 17'(rsp_free_blocks)) <= 17'd65536)
		else $error("counts out of range");
endmodule

bind bitmap_frame_allocator bfa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_ok(rsp.ok), .rsp_alloc_address(rsp.alloc_address),
	.rsp_used_blocks(rsp.used_blocks), .rsp_free_blocks(rsp.free_blocks)
);

FILE: tb/testbench.sv
module testbench;
	import bfa_pkg::*;

	localparam int unsigned NBLK  = NUM_BLOCKS_DEF;
	localparam int unsigned BBYTE = BLOCK_BYTES_DEF;
	localparam int unsigned STALL_LIMIT = 200000;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] alloc_address;
		logic [CNT_W-1:0]  used_blocks;
		logic [CNT_W-1:0]  free_blocks;
	} status_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [MEMORY_KIB_W-1:0] cfg_wdata;

	bfa_req_if req ();
	bfa_rsp_if rsp ();

	bitmap_frame_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req.sink),
		.rsp      (rsp.source)
	);

	bit              used_map [NBLK];
	longint unsigned used_total;
	logic [MEMORY_KIB_W-1:0] mem_kib;
	status_t         pending_status [$];
	int unsigned     errors = 0;
	int unsigned     sent_count;
	int unsigned     seen_count = 0;
	int unsigned     alloc_hits;
	int unsigned     stall_cycles = 0;
	bit              steady;
	logic [ADDR_W-1:0] granted [$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned managed_count();
		longint unsigned m;
		m = (longint'(mem_kib) * 1024) / BBYTE;
		return (m > NBLK) ? NBLK : m;
	endfunction

	function automatic void map_clear_all();
		foreach (used_map[i]) used_map[i] = 1'b1;
		used_total = managed_count();
	endfunction

	function automatic void block_write(longint unsigned b, bit v);
		if (b >= managed_count()) return;
		if (used_map[b] != v) begin
			used_map[b] = v;
			if (v) used_total++;
			else used_total--;
		end
	endfunction

	function automatic void run_write(longint unsigned first, longint unsigned cnt, bit v);
		longint unsigned m;
		m = managed_count();
		for (longint unsigned b = first; b < first + cnt && b < m; b++)
			block_write(b, v);
	endfunction

	function automatic status_t allocator_step(cmd_t c, logic [ADDR_W-1:0] a,
			logic [LEN_W-1:0] len);
		status_t s;
		longint unsigned m, run, start;
		bit found;
		m = managed_count();
		s = '0;
		s.ok = 1'b1;
		case (c)
			CMD_RESET_MAP: map_clear_all();
			CMD_FREE_REGION: begin
				run_write(a / BBYTE, len / BBYTE, 1'b0);
				block_write(0, 1'b1);
			end
			CMD_RESERVE: run_write(a / BBYTE, len / BBYTE, 1'b1);
			CMD_ALLOC: begin
				found = 1'b0;
				run = 0;
				start = 0;
				if (len == 0 || (m - used_total) < len) begin
					s.ok = 1'b0;
				end else begin
					for (longint unsigned b = 0; b < m; b++) begin
						if (used_map[b]) begin
							run = 0;
						end else begin
							run++;
							if (run == len) begin
								start = b + 1 - len;
								found = 1'b1;
								break;
							end
						end
					end
					if (!found) begin
						s.ok = 1'b0;
					end else begin
						run_write(start, len, 1'b1);
						s.alloc_address = ADDR_W'(start * BBYTE);
					end
				end
			end
			CMD_FREE: run_write(a / BBYTE, len, 1'b0);
			default: s.ok = 1'b0;
		endcase
		s.used_blocks = used_total[CNT_W-1:0];
		s.free_blocks = CNT_W'(m - used_total);
		return s;
	endfunction

	always @(posedge clk) begin
		rsp.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 8);
	end

	always @(posedge clk) begin
		status_t want;
		status_t got;
		if (rsp.valid && rsp.ready) begin
			got = {rsp.ok, rsp.alloc_address, rsp.used_blocks, rsp.free_blocks};
			seen_count++;
			if (pending_status.size() == 0) begin
				$display("%0t: unexpected result ok=%0b addr=%h used=%0d free=%0d", $time,
					got.ok, got.alloc_address, got.used_blocks, got.free_blocks);
				errors++;
			end else begin
				want = pending_status.pop_front();
				if (got.ok !== want.ok) begin
					$display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
					errors++;
				end
				if (got.alloc_address !== want.alloc_address) begin
					$display("%0t: alloc_address expected %h actual %h", $time,
						want.alloc_address, got.alloc_address);
					errors++;
				end
				if (got.used_blocks !== want.used_blocks) begin
					$display("%0t: used_blocks expected %0d actual %0d", $time,
						want.used_blocks, got.used_blocks);
					errors++;
				end
				if (got.free_blocks !== want.free_blocks) begin
					$display("%0t: free_blocks expected %0d actual %0d", $time,
						want.free_blocks, got.free_blocks);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// call at a rising edge; returns at the edge where the request was taken
	task automatic send_request(cmd_t c, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] len);
		status_t s;
		if (!steady && $urandom_range(0, 99) < 8) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.cmd     <= c;
		req.address <= a;
		req.length  <= len;
		do @(posedge clk); while (!req.ready);
		s = allocator_step(c, a, len);
		if (c == CMD_ALLOC && s.ok) begin
			alloc_hits++;
			granted.push_back(s.alloc_address);
		end
		pending_status.push_back(s);
		sent_count++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_memory_size(logic [MEMORY_KIB_W-1:0] kib);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= kib;
		@(posedge clk);
		cfg_we <= 1'b0;
		mem_kib = kib;
		map_clear_all();
		granted.delete();
	endtask

	function automatic logic [ADDR_W-1:0] block_addr(longint unsigned b);
		return ADDR_W'(b * BBYTE + $urandom_range(0, BBYTE - 1));
	endfunction

	task automatic test_directed();
		send_request(CMD_ALLOC, 32'h0, 32'h0);
		send_request(CMD_ALLOC, 32'h0, 32'h1);
		send_request(CMD_FREE_REGION, 32'h0, 32'h10000);
		send_request(CMD_ALLOC, 32'h0, 32'h1);
		send_request(CMD_ALLOC, 32'h0, 32'hFFFFFFFF);
		send_request(CMD_RESERVE, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(CMD_FREE, 32'hFFFFF000, 32'hFFFFFFFF);
		send_request(CMD_FREE, 32'h07FFF000, 32'hFFFFFFFF);
		send_request(CMD_ALLOC, 32'h0, 32'h2);
		send_request(CMD_ALLOC, 32'h0, 32'd20);
		send_request(CMD_ALLOC, 32'h0, 32'd14);
		send_request(CMD_FREE, 32'h00001000, 32'd3);
		send_request(CMD_FREE, 32'h00001000, 32'd3);
		send_request(CMD_RESERVE, 32'h00001FFF, 32'h00001FFF);
		send_request(CMD_RESERVE, 32'h00001000, 32'h00002000);
		send_request(CMD_BAD5, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(CMD_BAD6, 32'h0, 32'h0);
		send_request(CMD_BAD7, 32'h12345678, 32'h9ABCDEF0);
		send_request(CMD_ALLOC, 32'h0, 32'h1);
		send_request(CMD_FREE_REGION, 32'h0, 32'hFFFFFFFF);
		send_request(CMD_ALLOC, 32'h0, 32'h100);
		send_request(CMD_RESET_MAP, 32'h0, 32'h0);
		send_request(CMD_ALLOC, 32'h0, 32'h1);
		drain();
	endtask

	task automatic random_request();
		longint unsigned m;
		int unsigned pick;
		m = managed_count();
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			send_request(cmd_t'($urandom_range(0, 7)), $urandom, $urandom);
		end else if (pick < 14) begin
			send_request(CMD_FREE_REGION, 32'h0, LEN_W'((m + 4) * BBYTE));
		end else if (pick < 16) begin
			send_request(CMD_RESET_MAP, $urandom, $urandom);
		end else if (pick < 26) begin
			send_request(CMD_FREE_REGION, block_addr($urandom_range(0, m + 2)),
				$urandom_range(0, 24 * BBYTE));
		end else if (pick < 36) begin
			send_request(CMD_RESERVE, block_addr($urandom_range(0, m + 2)),
				$urandom_range(0, 16 * BBYTE));
		end else if (pick < 68) begin
			send_request(CMD_ALLOC, $urandom, $urandom_range(1, 12));
		end else if (granted.size() != 0) begin
			send_request(CMD_FREE, granted[$urandom_range(0, granted.size() - 1)],
				$urandom_range(1, 12));
		end else begin
			send_request(CMD_FREE, block_addr($urandom_range(0, m)), $urandom_range(0, 20));
		end
	endtask

	task automatic test_memory_sizes();
		logic [MEMORY_KIB_W-1:0] sizes [8];
		sizes = '{18'd0, 18'd3, 18'd4, 18'd131072, 18'd262143, 18'd131071, 18'd129, 18'd7};
		foreach (sizes[i]) begin
			write_memory_size(sizes[i]);
			send_request(CMD_FREE_REGION, 32'h0, 32'h40000);
			repeat (12) random_request();
			send_request(CMD_RESET_MAP, 32'h0, 32'h0);
		end
		drain();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			write_memory_size(MEMORY_KIB_W'($urandom_range(128, 1024)));
			steady = (phase == 3);
			send_request(CMD_FREE_REGION, 32'h0, 32'hFFFFFFFF);
			repeat (200) random_request();
		end
		steady = 1'b0;
		drain();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		req.valid   = 1'b0;
		req.cmd     = CMD_RESET_MAP;
		req.address = '0;
		req.length  = '0;
		steady      = 1'b0;
		sent_count  = 0;
		alloc_hits  = 0;
		mem_kib     = MEMORY_KIB_RST;
		map_clear_all();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_memory_sizes();
		test_random_traffic();
		$display("Covered %0d requests and %0d results, %0d successful allocations,",
			sent_count, seen_count, alloc_hits);
		$display("over empty, tiny, default and oversized memory sizes.");
		if (errors == 0 && pending_status.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: bitmap_frame_allocator.f
rtl/bfa_pkg.sv
rtl/bfa_if.sv
rtl/bfa_front.sv
rtl/bfa_back.sv
rtl/bitmap_frame_allocator.sv
rtl/bfa_checker.sv
tb/testbench.sv
